// File: rtl/core/medt_pkg.sv
`timescale 1ns / 1ps

package medt_pkg;

  localparam int EDGE_NUM_W = 13;
  localparam int QUAD_NODES = 4;

  localparam logic REQ_BOUNDARY = 1'b0;
  localparam logic REQ_CELL     = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIDE,
    S_HEAD,
    S_WALK,
    S_INSERT,
    S_CLEAR
  } medt_state_t;

endpackage

// File: rtl/core/mesh_edge_dedup_table.sv
`timescale 1ns / 1ps

// per side: S_SIDE and S_HEAD for key and bucket head, S_WALK per chain entry, S_INSERT appends
// boundary: S_SIDE, S_HEAD, S_WALK only when its bucket is in use, then S_INSERT; never a hit
// cell: 3 or 4 sides one after another, each lasting as long as its chain walk
// throughput: one item at a time, start taken again in the cycle the last result shows
// each result shows for one cycle with result_valid; the receiver cannot stall
// rst (synchronous) empties the table, then S_CLEAR clears the 1 << $clog2(MAX_EDGES) heads (4096)
module mesh_edge_dedup_table import medt_pkg::*; #(
  parameter int MAX_EDGES = 4096,
  parameter int NODE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [2:0]            node_count,
  input  logic [NODE_BITS-1:0]  node_a,
  input  logic [NODE_BITS-1:0]  node_b,
  input  logic [NODE_BITS-1:0]  node_c,
  input  logic [NODE_BITS-1:0]  node_d,
  output logic                  result_valid,
  output logic [EDGE_NUM_W-1:0] edge_number,
  output logic [NODE_BITS-1:0]  low_node,
  output logic [NODE_BITS-1:0]  high_node,
  output logic                  is_new,
  output logic                  table_full,
  output logic                  last
);

  localparam int IDX_W      = $clog2(MAX_EDGES);
  localparam int PTR_W      = $clog2(MAX_EDGES + 1);
  localparam int HASH_W     = IDX_W;
  localparam int HEAD_DEPTH = 1 << HASH_W;
  localparam int KEY_W      = 2 * NODE_BITS;
  localparam int ENT_W      = PTR_W + KEY_W;
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(MAX_EDGES);
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  function automatic logic [HASH_W-1:0] key_hash(input logic [NODE_BITS-1:0] lo,
                                                 input logic [NODE_BITS-1:0] hi);
    logic [KEY_W-1:0]  k;
    logic [HASH_W-1:0] h;
    k = {lo, hi};
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % HASH_W] = h[i % HASH_W] ^ k[i];
    end
    return h;
  endfunction

  // memories: entry = {next pointer, key}, head = newest pointer per hash bucket
  logic [ENT_W-1:0] ent_mem  [MAX_EDGES];
  logic [PTR_W-1:0] head_mem [HEAD_DEPTH];

  medt_state_t state, state_next;

  logic [1:0]           side;
  logic [1:0]           last_side;
  logic                 is_cell;
  logic [NODE_BITS-1:0] n0, n1, n2, n3;
  logic [NODE_BITS-1:0] low_r, high_r;
  logic [HASH_W-1:0]    hash_r;
  logic [PTR_W-1:0]     link;
  logic [PTR_W-1:0]     cur;
  logic [PTR_W-1:0]     total;
  logic [PTR_W-1:0]     head_q;
  logic [ENT_W-1:0]     ent_q;
  logic [HASH_W-1:0]    clr_idx;

  logic [NODE_BITS-1:0] p_c, q_c, lo_c, hi_c;
  logic [HASH_W-1:0]    hash_c;
  logic                 head_ok;
  logic [PTR_W-1:0]     ent_next;
  logic [NODE_BITS-1:0] ent_lo, ent_hi;
  logic                 hash_bad;
  logic                 key_hit;
  logic                 side_last;
  logic                 room;

  logic                 head_rd, head_wr;
  logic [HASH_W-1:0]    head_wr_addr;
  logic [PTR_W-1:0]     head_wr_data;
  logic                 ent_rd, ent_wr;
  logic [IDX_W-1:0]     ent_rd_addr;

  // side endpoints
  always_comb begin
    case (side)
      2'd0: begin
        p_c = n0;
        q_c = n1;
      end
      2'd1: begin
        p_c = n1;
        q_c = n2;
      end
      2'd2: begin
        p_c = n2;
        q_c = (last_side == 2'd2) ? n0 : n3;
      end
      default: begin
        p_c = n3;
        q_c = n0;
      end
    endcase
    lo_c   = (p_c < q_c) ? p_c : q_c;
    hi_c   = (p_c < q_c) ? q_c : p_c;
    hash_c = key_hash(lo_c, hi_c);
  end

  assign head_ok   = (head_q != '0) && (head_q <= total);
  assign ent_next  = ent_q[ENT_W-1 -: PTR_W];
  assign ent_lo    = ent_q[KEY_W-1 -: NODE_BITS];
  assign ent_hi    = ent_q[NODE_BITS-1:0];
  assign hash_bad  = key_hash(ent_lo, ent_hi) != hash_r;
  assign key_hit   = is_cell && (ent_lo == low_r) && (ent_hi == high_r);
  assign side_last = (side == last_side);
  assign room      = (total < PTR_MAX);
  assign busy      = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_SIDE;
      end
      S_SIDE: state_next = S_HEAD;
      S_HEAD: begin
        state_next = head_ok ? S_WALK : S_INSERT;
      end
      S_WALK: begin
        if (!is_cell || hash_bad) state_next = S_INSERT;
        else if (key_hit) state_next = side_last ? S_IDLE : S_SIDE;
        else if (ent_next != '0) state_next = S_WALK;
        else state_next = S_INSERT;
      end
      S_INSERT: state_next = side_last ? S_IDLE : S_SIDE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    head_rd      = 1'b0;
    head_wr      = 1'b0;
    head_wr_addr = hash_r;
    head_wr_data = total + PTR_ONE;
    ent_rd       = 1'b0;
    ent_wr       = 1'b0;
    ent_rd_addr  = IDX_W'(head_q - PTR_ONE);
    case (state)
      S_CLEAR: begin
        head_wr      = 1'b1;
        head_wr_addr = clr_idx;
        head_wr_data = '0;
      end
      S_SIDE: head_rd = 1'b1;
      S_HEAD: ent_rd = head_ok;
      S_WALK: begin
        ent_rd_addr = IDX_W'(ent_next - PTR_ONE);
        ent_rd      = is_cell && !hash_bad && !key_hit && (ent_next != '0);
      end
      S_INSERT: begin
        ent_wr  = room;
        head_wr = room;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_rd) head_q <= head_mem[hash_c];
    if (head_wr) head_mem[head_wr_addr] <= head_wr_data;
  end

  always_ff @(posedge clk) begin
    if (ent_rd) ent_q <= ent_mem[ent_rd_addr];
    if (ent_wr) ent_mem[IDX_W'(total)] <= {link, low_r, high_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= ((state == S_WALK) && is_cell && !hash_bad && key_hit) ||
                      (state == S_INSERT);
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if ((state == S_INSERT) && room) total <= total + PTR_ONE;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          n0      <= node_a;
          n1      <= node_b;
          n2      <= node_c;
          n3      <= node_d;
          is_cell <= (req_type == REQ_CELL);
          side    <= 2'd0;
          if (req_type == REQ_BOUNDARY) last_side <= 2'd0;
          else if (node_count >= 3'(QUAD_NODES)) last_side <= 2'd3;
          else last_side <= 2'd2;
        end
      end
      S_SIDE: begin
        low_r  <= lo_c;
        high_r <= hi_c;
        hash_r <= hash_c;
      end
      S_HEAD: begin
        link <= head_ok ? head_q : '0;
        cur  <= head_q;
      end
      S_WALK: begin
        if (hash_bad) begin
          link <= '0;
        end else if (key_hit) begin
          edge_number <= EDGE_NUM_W'(cur);
          low_node    <= low_r;
          high_node   <= high_r;
          is_new      <= 1'b0;
          table_full  <= 1'b0;
          last        <= side_last;
          side        <= side + 2'd1;
        end else if (ent_rd) begin
          cur <= ent_next;
        end
      end
      S_INSERT: begin
        edge_number <= room ? EDGE_NUM_W'(total + PTR_ONE) : '0;
        low_node    <= low_r;
        high_node   <= high_r;
        is_new      <= room;
        table_full  <= !room;
        last        <= side_last;
        side        <= side + 2'd1;
      end
      default: ;
    endcase
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst) total <= PTR_MAX)
    else $error("edge count beyond table size");

  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_new |-> total == $past(total) + PTR_ONE)
    else $error("new edge without count step");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && table_full |-> edge_number == '0 && !is_new && total == PTR_MAX)
    else $error("full result inconsistent");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("still busy after last result");

  a_walk_descends: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && $past(state) == S_WALK |-> cur < $past(cur))
    else $error("chain walk not descending");

endmodule
